// ----- rtl/core/bgc_pkg.sv -----
package bgc_pkg;

  localparam int NUM_TRACKS = 16;
  localparam int NUM_GROUPS = 8;
  localparam int NUM_UNITS  = NUM_TRACKS + NUM_GROUPS;

  localparam int BUTTON_W   = 5;
  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 20;
  localparam int WINDOW_W   = 24;
  localparam int UNIT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // two bits above the button field so unit counts up to 127 compare cleanly
  localparam int CMP_W = BUTTON_W + 2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST    = DEBOUNCE_W'(20000);
  localparam logic [WINDOW_W-1:0]   DOUBLE_PRESS_RST = WINDOW_W'(1000000);
  localparam logic [WINDOW_W-1:0]   LONG_HOLD_RST    = WINDOW_W'(1000000);

  typedef enum logic [1:0] {
    GEST_PRESS  = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_SHORT  = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_DOUBLE_PRESS = 2'd1,
    CFG_LONG_HOLD    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    logic                level;
    logic [TIME_W-1:0]   time_us;
  } item_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_us;
    logic [WINDOW_W-1:0]   double_press_us;
    logic [WINDOW_W-1:0]   long_hold_us;
  } cfg_t;

  typedef struct packed {
    gesture_t          gesture;
    logic              for_track;
    logic [UNIT_W-1:0] unit_index;
  } result_t;

endpackage

// ----- rtl/core/bgc_cfg_regs.sv -----
module bgc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bgc_pkg::cfg_t                 cfg
);
  import bgc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:     cfg_nxt.debounce_us     = cfg_wdata[DEBOUNCE_W-1:0];
        CFG_DOUBLE_PRESS: cfg_nxt.double_press_us = cfg_wdata[WINDOW_W-1:0];
        CFG_LONG_HOLD:    cfg_nxt.long_hold_us    = cfg_wdata[WINDOW_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_us     <= DEBOUNCE_RST;
      cfg_r.double_press_us <= DOUBLE_PRESS_RST;
      cfg_r.long_hold_us    <= LONG_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/bgc_classify.sv -----
module bgc_classify (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bgc_pkg::item_t   item,
  input  bgc_pkg::cfg_t    cfg,
  output logic             res_vld,
  output bgc_pkg::result_t res
);
  import bgc_pkg::*;

  logic              last_level_r, last_level_nxt;
  logic              level_known_r, level_known_nxt;
  logic [TIME_W-1:0] last_edge_time_r, last_edge_time_nxt;
  logic              edge_seen_r, edge_seen_nxt;
  logic [TIME_W-1:0] last_press_time_r, last_press_time_nxt;
  logic              press_seen_r, press_seen_nxt;

  logic              known_btn;
  logic              repeat_lvl;
  logic              bounced;
  logic [TIME_W-1:0] edge_elapsed;
  logic [TIME_W-1:0] press_elapsed;
  logic              is_track;

  assign known_btn     = CMP_W'(item.button) < CMP_W'(NUM_UNITS);
  assign is_track      = CMP_W'(item.button) < CMP_W'(NUM_TRACKS);
  assign repeat_lvl    = level_known_r && (item.level == last_level_r);
  assign edge_elapsed  = item.time_us - last_edge_time_r;
  assign press_elapsed = item.time_us - last_press_time_r;
  // full elapsed time against the threshold, wrap-safe
  assign bounced       = edge_seen_r && (edge_elapsed < TIME_W'(cfg.debounce_us));

  always_comb begin
    last_level_nxt      = last_level_r;
    level_known_nxt     = level_known_r;
    last_edge_time_nxt  = last_edge_time_r;
    edge_seen_nxt       = edge_seen_r;
    last_press_time_nxt = last_press_time_r;
    press_seen_nxt      = press_seen_r;
    res_vld             = 1'b0;
    res.gesture         = GEST_PRESS;
    res.for_track       = is_track;
    res.unit_index      = is_track ? item.button[UNIT_W-1:0]
                                   : UNIT_W'(CMP_W'(item.button) - CMP_W'(NUM_TRACKS));

    if (item.level == 1'b0) begin
      if (press_seen_r && (press_elapsed < TIME_W'(cfg.double_press_us))) begin
        res.gesture = GEST_DOUBLE;
      end
    end else if (!press_seen_r || (press_elapsed > TIME_W'(cfg.long_hold_us))) begin
      res.gesture = GEST_LONG;
    end else begin
      res.gesture = GEST_SHORT;
    end

    if (fire && known_btn && !repeat_lvl) begin
      // a bounced edge still moves the edge time
      last_edge_time_nxt = item.time_us;
      edge_seen_nxt      = 1'b1;
      if (!bounced) begin
        res_vld         = 1'b1;
        last_level_nxt  = item.level;
        level_known_nxt = 1'b1;
        if (item.level == 1'b0) begin
          last_press_time_nxt = item.time_us;
          press_seen_nxt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r      <= 1'b0;
      level_known_r     <= 1'b0;
      last_edge_time_r  <= '0;
      edge_seen_r       <= 1'b0;
      last_press_time_r <= '0;
      press_seen_r      <= 1'b0;
    end else begin
      last_level_r      <= last_level_nxt;
      level_known_r     <= level_known_nxt;
      last_edge_time_r  <= last_edge_time_nxt;
      edge_seen_r       <= edge_seen_nxt;
      last_press_time_r <= last_press_time_nxt;
      press_seen_r      <= press_seen_nxt;
    end
  end

endmodule

// ----- rtl/core/button_gesture_classifier.sv -----
// Classifies timestamped level changes from the track and group buttons into
// press, double press, short pulse and long pulse events; all buttons share one
// remembered level, one debounce timer and one press timer, and edges that
// repeat the level, bounce, or name an unknown button produce no event.
// Throughput is one edge per clock while out_stall does not hold the result;
// an event passes through the input register, which holds the edge while the
// classify logic settles, and then the result register, which presents it.
// Thresholds are written through the cfg port
// (index 0 debounce, 1 double-press window, 2 hold threshold, microseconds)
// by the user only while no edge is in flight; the block does not enforce this.
module button_gesture_classifier (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bgc_pkg::BUTTON_W-1:0]   in_button,
  input  logic                           in_level,
  input  logic [bgc_pkg::TIME_W-1:0]     in_time_us,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_gesture,
  output logic                           out_for_track,
  output logic [bgc_pkg::UNIT_W-1:0]     out_unit_index,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bgc_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_vld_r, s1_vld_nxt;
  logic    out_vld_r, out_vld_nxt;
  result_t out_res_r;
  logic    advance;
  logic    in_xfer;
  logic    res_vld;
  result_t res;

  bgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bgc_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  // stage 1 moves on whenever the result slot is free or drains this cycle
  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid      = out_vld_r;
  assign out_gesture    = out_res_r.gesture;
  assign out_for_track  = out_res_r.for_track;
  assign out_unit_index = out_res_r.unit_index;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = res_vld;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.button  <= in_button;
      s1_item_r.level   <= in_level;
      s1_item_r.time_us <= in_time_us;
    end
    if (advance && res_vld) begin
      out_res_r <= res;
    end
  end

endmodule
